FILE: rtl/hcc_pkg.sv
// Package for the hit coincidence clusterer.
// Shared constants, widths and the hit record type. No dependencies.
package hcc_pkg;
  localparam int MAX_HITS_DEF = 1024;
  localparam int SEC_W = 32;
  localparam int NS_W = 30;
  localparam int PLANE_W = 2;
  localparam int CHG_W = 16;
  localparam int CSUM_W = 26;
  localparam int HCNT_W = 11;
  localparam logic [NS_W-1:0] WINDOW_RST = 30'd100;
  localparam int SUM_W = 48;

  typedef struct packed {
    logic [SEC_W-1:0] second;
    logic [NS_W-1:0] coarse;
    logic [NS_W-1:0] fine;
    logic [PLANE_W-1:0] plane;
    logic [CHG_W-1:0] charge;
  } hit_t;
endpackage

FILE: rtl/hcc_div.sv
// Signed sum divided by unsigned count, truncated toward zero, one bit per cycle.
// Depends on hcc_pkg.
module hcc_div #(
  parameter int CNT_W = 17
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [hcc_pkg::SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic done,
  output logic signed [hcc_pkg::SUM_W-1:0] quotient
);
  localparam int W = hcc_pkg::SUM_W;
  localparam int STEP_W = $clog2(W + 1);

  logic busy;
  logic neg;
  logic [STEP_W-1:0] step;
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] den;
  logic [W:0] trial;

  assign trial = {rem[W-2:0], quo[W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(W);
        neg <= dividend[W-1];
        quo <= dividend[W-1] ? W'(-dividend) : W'(dividend);
        rem <= '0;
        den <= W'(divisor);
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quo[W-1]};
          quo <= {quo[W-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule

FILE: rtl/hcc_store.sv
// Hit memory and used-mark memory, one read port each, registered read data.
// Depends on hcc_pkg.
module hcc_store #(
  parameter int MAX_HITS = hcc_pkg::MAX_HITS_DEF,
  localparam int AW = $clog2(MAX_HITS)
) (
  input  logic clk,
  input  logic hit_we,
  input  logic [AW-1:0] hit_waddr,
  input  hcc_pkg::hit_t hit_wdata,
  input  logic [AW-1:0] raddr,
  output hcc_pkg::hit_t hit_rdata,
  input  logic mark_we,
  input  logic [AW-1:0] mark_waddr,
  input  logic mark_wdata,
  output logic mark_rdata
);
  hcc_pkg::hit_t hits [MAX_HITS];
  logic marks [MAX_HITS];

  always_ff @(posedge clk) begin
    if (hit_we) hits[hit_waddr] <= hit_wdata;
    hit_rdata <= hits[raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) marks[mark_waddr] <= mark_wdata;
    mark_rdata <= marks[raddr];
  end
endmodule

FILE: rtl/hit_coincidence_clusterer.sv
// Top level of the hit coincidence clusterer: sequencer, accumulators, outputs.
// Depends on hcc_pkg, hcc_store, hcc_div.
//
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   kind, hit_*
// out      output     out_valid/out_ready cluster_second .. last
// cfg      input      cfg_we              cfg_data (coincidence window)
//
// A cluster request scans from the seed position to the fill count through the
// registered memory read, then runs the two 48-step serial divisions, then loads
// the output registers. After the result with last set, a clearing pass writes
// MAX_HITS used marks to zero, one per cycle; after reset the same pass runs, and
// no transaction is taken. in_ready is low outside idle; a waiting result stalls
// only the output step.
module hit_coincidence_clusterer #(
  parameter int MAX_HITS = hcc_pkg::MAX_HITS_DEF,
  localparam int AW = $clog2(MAX_HITS),
  localparam int CW = $clog2(MAX_HITS + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic kind,
  input  logic [31:0] hit_second,
  input  logic [29:0] hit_coarse_ns,
  input  logic [29:0] hit_fine_ns,
  input  logic [1:0] hit_plane,
  input  logic [15:0] hit_charge,
  output logic out_valid,
  input  logic out_ready,
  output logic [31:0] cluster_second,
  output logic [29:0] mean_coarse_ns,
  output logic [29:0] mean_fine_ns,
  output logic [10:0] plane0_hits,
  output logic [10:0] plane1_hits,
  output logic [10:0] plane2_hits,
  output logic [10:0] plane3_hits,
  output logic [25:0] plane0_charge,
  output logic [25:0] plane1_charge,
  output logic [25:0] plane2_charge,
  output logic [25:0] plane3_charge,
  output logic last,
  input  logic cfg_we,
  input  logic [29:0] cfg_data
);
  localparam int SW = hcc_pkg::SUM_W;
  localparam int NS = hcc_pkg::NS_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIVC = 3'd3;
  localparam logic [2:0] S_DIVF = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [NS-1:0] window;
  logic [CW-1:0] loaded;
  logic [CW-1:0] seed_pos;
  logic [CW-1:0] rptr;
  logic [CW-1:0] next_seed;
  logic next_found;
  logic rvalid;
  logic [CW-1:0] rpos;
  logic have_seed;
  hcc_pkg::hit_t seed;
  logic [CW-1:0] count;
  logic signed [SW-1:0] csum;
  logic signed [SW-1:0] fsum;
  logic [10:0] hcnt [4];
  logic [25:0] chg [4];
  logic [AW-1:0] clr_ptr;
  logic [NS-1:0] avg_coarse;
  logic [NS-1:0] avg_fine;

  hcc_pkg::hit_t wdata;
  hcc_pkg::hit_t rdata;
  logic mark_rd;
  logic mark_we;
  logic [AW-1:0] mark_waddr;
  logic mark_wdata;
  logic hit_we;

  logic div_start;
  logic div_done;
  logic signed [SW-1:0] div_num;
  logic signed [SW-1:0] quo;

  logic in_acc;
  logic out_load;
  logic signed [SW-1:0] df;
  logic signed [SW-1:0] dc;
  logic [SW-1:0] mag;
  logic match;

  assign in_ready = (state == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  assign wdata = '{second: hit_second, coarse: hit_coarse_ns, fine: hit_fine_ns,
                   plane: hit_plane, charge: hit_charge};
  assign hit_we = in_acc && !kind && (loaded != CW'(MAX_HITS));

  assign df = SW'($signed({1'b0, rdata.fine})) - SW'($signed({1'b0, seed.fine}));
  assign dc = SW'($signed({1'b0, rdata.coarse})) - SW'($signed({1'b0, seed.coarse}));
  assign mag = df[SW-1] ? SW'(-df) : SW'(df);
  assign match = rdata.second == seed.second && mag < SW'(window);

  always_comb begin
    mark_we = 1'b0;
    mark_waddr = clr_ptr;
    mark_wdata = 1'b0;
    if (state == S_CLEAR) begin
      mark_we = 1'b1;
    end else if (hit_we) begin
      mark_we = 1'b1;
      mark_waddr = loaded[AW-1:0];
    end else if (state == S_SCAN && rvalid && !mark_rd && (!have_seed || match)) begin
      mark_we = 1'b1;
      mark_waddr = rpos[AW-1:0];
      mark_wdata = 1'b1;
    end
  end

  hcc_store #(.MAX_HITS(MAX_HITS)) u_store (
    .clk(clk), .hit_we(hit_we), .hit_waddr(loaded[AW-1:0]), .hit_wdata(wdata),
    .raddr(rptr[AW-1:0]), .hit_rdata(rdata), .mark_we(mark_we),
    .mark_waddr(mark_waddr), .mark_wdata(mark_wdata), .mark_rdata(mark_rd)
  );

  assign div_num = (state == S_DIVC) ? csum : fsum;

  hcc_div #(.CNT_W(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(count),
    .done(div_done), .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_ptr <= '0;
      window <= hcc_pkg::WINDOW_RST;
      loaded <= '0;
      seed_pos <= '0;
      out_valid <= 1'b0;
      rvalid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) window <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == AW'(MAX_HITS - 1)) begin
            state <= S_IDLE;
            loaded <= '0;
            seed_pos <= '0;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (!kind) begin
              if (hit_we) loaded <= loaded + 1'b1;
            end else if (seed_pos < loaded) begin
              state <= S_SCAN;
              rptr <= seed_pos;
              rvalid <= 1'b0;
              have_seed <= 1'b0;
              next_found <= 1'b0;
              count <= '0;
              csum <= '0;
              fsum <= '0;
              for (int p = 0; p < 4; p++) begin
                hcnt[p] <= '0;
                chg[p] <= '0;
              end
            end
          end
        end
        S_SCAN: begin
          rvalid <= rptr < loaded;
          rpos <= rptr;
          if (rptr < loaded) rptr <= rptr + 1'b1;
          if (rvalid && !mark_rd) begin
            if (!have_seed) begin
              have_seed <= 1'b1;
              seed <= rdata;
              count <= CW'(1);
              hcnt[rdata.plane] <= 11'd1;
              chg[rdata.plane] <= 26'(rdata.charge);
            end else if (match) begin
              count <= count + 1'b1;
              csum <= csum + dc;
              fsum <= fsum + df;
              hcnt[rdata.plane] <= hcnt[rdata.plane] + 1'b1;
              chg[rdata.plane] <= chg[rdata.plane] + 26'(rdata.charge);
            end else if (!next_found) begin
              next_found <= 1'b1;
              next_seed <= rpos;
            end
          end
          if (!rvalid && rptr >= loaded && have_seed) begin
            state <= S_DIVC;
            div_start <= 1'b1;
          end
        end
        S_DIVC: begin
          if (div_done) begin
            avg_coarse <= NS'(SW'($signed({1'b0, seed.coarse})) + quo);
            state <= S_DIVF;
            div_start <= 1'b1;
          end
        end
        S_DIVF: begin
          if (div_done) begin
            avg_fine <= NS'(SW'($signed({1'b0, seed.fine})) + quo);
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            cluster_second <= seed.second;
            mean_coarse_ns <= avg_coarse;
            mean_fine_ns <= avg_fine;
            plane0_hits <= hcnt[0];
            plane1_hits <= hcnt[1];
            plane2_hits <= hcnt[2];
            plane3_hits <= hcnt[3];
            plane0_charge <= chg[0];
            plane1_charge <= chg[1];
            plane2_charge <= chg[2];
            plane3_charge <= chg[3];
            last <= !next_found;
            if (next_found) begin
              seed_pos <= next_seed;
              state <= S_IDLE;
            end else begin
              clr_ptr <= '0;
              state <= S_CLEAR;
            end
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cluster_second))
    else $error("result dropped");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    loaded <= CW'(MAX_HITS)) else $error("fill count overflow");
  a_seed: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> seed_pos <= loaded) else $error("seed past fill");
endmodule

FILE: bench/hcc_tb_pkg.sv
`timescale 1ns / 1ps
// Shared testbench types for the hit coincidence clusterer bench.
// Depends on hcc_pkg for field widths.
package hcc_tb_pkg;
  typedef enum logic {KIND_LOAD = 1'b0, KIND_CLUSTER = 1'b1} kind_e;

  typedef struct {
    logic [hcc_pkg::SEC_W-1:0] second;
    logic [hcc_pkg::NS_W-1:0] coarse;
    logic [hcc_pkg::NS_W-1:0] fine;
    logic [hcc_pkg::HCNT_W-1:0] hits [4];
    logic [hcc_pkg::CSUM_W-1:0] charge [4];
    logic last;
  } cluster_t;
endpackage

FILE: bench/hcc_checker.sv
`timescale 1ns / 1ps
// Cluster predictor and scoreboard for hit_coincidence_clusterer.
// Depends on hcc_pkg and hcc_tb_pkg; watches the in, out and cfg ports.
module hcc_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic kind,
  input  logic [31:0] hit_second,
  input  logic [29:0] hit_coarse_ns,
  input  logic [29:0] hit_fine_ns,
  input  logic [1:0] hit_plane,
  input  logic [15:0] hit_charge,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [31:0] cluster_second,
  input  logic [29:0] mean_coarse_ns,
  input  logic [29:0] mean_fine_ns,
  input  logic [10:0] plane0_hits,
  input  logic [10:0] plane1_hits,
  input  logic [10:0] plane2_hits,
  input  logic [10:0] plane3_hits,
  input  logic [25:0] plane0_charge,
  input  logic [25:0] plane1_charge,
  input  logic [25:0] plane2_charge,
  input  logic [25:0] plane3_charge,
  input  logic last,
  input  logic cfg_we,
  input  logic [29:0] cfg_data,
  output int fail_count,
  output int pending_clusters
);
  localparam int DEPTH = hcc_pkg::MAX_HITS_DEF;
  localparam int NS_W = hcc_pkg::NS_W;
  localparam int HCNT_W = hcc_pkg::HCNT_W;
  localparam int CSUM_W = hcc_pkg::CSUM_W;

  hcc_pkg::hit_t hit_store [DEPTH];
  logic [DEPTH-1:0] used_marks;
  int fill_count;
  int seed_pos;
  logic [NS_W-1:0] window_ns;
  hcc_tb_pkg::cluster_t cluster_q [$];

  assign pending_clusters = cluster_q.size();

  task automatic predict_transaction(input logic k, input hcc_pkg::hit_t h);
    int seed;
    int n;
    longint fine_sum, coarse_sum, df;
    longint hsum [4];
    longint csum [4];
    hcc_tb_pkg::cluster_t c;
    fine_sum = 0;
    coarse_sum = 0;
    n = 1;
    if (k == hcc_tb_pkg::KIND_LOAD) begin
      if (fill_count < DEPTH) begin
        hit_store[fill_count] = h;
        used_marks[fill_count] = 1'b0;
        fill_count++;
      end
      return;
    end
    seed = seed_pos;
    while (seed < fill_count && used_marks[seed]) seed++;
    if (seed >= fill_count) return;
    for (int p = 0; p < 4; p++) begin
      hsum[p] = 0;
      csum[p] = 0;
    end
    used_marks[seed] = 1'b1;
    hsum[hit_store[seed].plane] = 1;
    csum[hit_store[seed].plane] = hit_store[seed].charge;
    for (int j = seed + 1; j < fill_count; j++) begin
      if (used_marks[j] || hit_store[j].second != hit_store[seed].second) continue;
      df = longint'(hit_store[j].fine) - longint'(hit_store[seed].fine);
      if ((df < 0 ? -df : df) >= longint'(window_ns)) continue;
      used_marks[j] = 1'b1;
      hsum[hit_store[j].plane] += 1;
      csum[hit_store[j].plane] += hit_store[j].charge;
      fine_sum += df;
      coarse_sum += longint'(hit_store[j].coarse) - longint'(hit_store[seed].coarse);
      n++;
    end
    c.second = hit_store[seed].second;
    c.coarse = NS_W'(longint'(hit_store[seed].coarse) + coarse_sum / n);
    c.fine = NS_W'(longint'(hit_store[seed].fine) + fine_sum / n);
    for (int p = 0; p < 4; p++) begin
      c.hits[p] = HCNT_W'(hsum[p]);
      c.charge[p] = CSUM_W'(csum[p]);
    end
    seed_pos = seed + 1;
    while (seed_pos < fill_count && used_marks[seed_pos]) seed_pos++;
    c.last = (seed_pos >= fill_count);
    if (c.last) begin
      used_marks = '0;
      fill_count = 0;
      seed_pos = 0;
    end
    cluster_q.insert(cluster_q.size(), c);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_cluster();
    hcc_tb_pkg::cluster_t c;
    logic [10:0] got_hits [4];
    logic [25:0] got_charge [4];
    got_hits = '{plane0_hits, plane1_hits, plane2_hits, plane3_hits};
    got_charge = '{plane0_charge, plane1_charge, plane2_charge, plane3_charge};
    if (cluster_q.size() == 0) begin
      $error("cluster transaction with no prediction pending");
      fail_count++;
      return;
    end
    c = cluster_q.pop_front();
    check_field("cluster_second", c.second, cluster_second);
    check_field("mean_coarse_ns", c.coarse, mean_coarse_ns);
    check_field("mean_fine_ns", c.fine, mean_fine_ns);
    for (int p = 0; p < 4; p++) begin
      check_field($sformatf("plane%0d_hits", p), c.hits[p], got_hits[p]);
      check_field($sformatf("plane%0d_charge", p), c.charge[p], got_charge[p]);
    end
    check_field("last", c.last, last);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      used_marks = '0;
      fill_count = 0;
      seed_pos = 0;
      window_ns = hcc_pkg::WINDOW_RST;
      cluster_q.delete();
    end else begin
      if (cfg_we) window_ns = cfg_data;
      if (in_valid && in_ready)
        predict_transaction(kind, '{hit_second, hit_coarse_ns, hit_fine_ns, hit_plane,
                                    hit_charge});
      if (out_valid && out_ready) check_cluster();
    end
  end
endmodule

FILE: bench/tb_hit_coincidence_clusterer.sv
`timescale 1ns / 1ps
// Top of the hit_coincidence_clusterer bench: clock, reset, stimulus and verdict.
// Depends on hcc_pkg, hcc_tb_pkg, hcc_checker and the RTL top.
module tb_hit_coincidence_clusterer;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int ITEM_TARGET = 580;
  localparam int NS_MAX = 999999999;

  logic clk, rst;
  logic in_valid, in_ready, kind;
  logic [31:0] hit_second;
  logic [29:0] hit_coarse_ns, hit_fine_ns;
  logic [1:0] hit_plane;
  logic [15:0] hit_charge;
  logic out_valid, out_ready;
  logic [31:0] cluster_second;
  logic [29:0] mean_coarse_ns, mean_fine_ns;
  logic [10:0] plane0_hits, plane1_hits, plane2_hits, plane3_hits;
  logic [25:0] plane0_charge, plane1_charge, plane2_charge, plane3_charge;
  logic last;
  logic cfg_we;
  logic [29:0] cfg_data;
  int fail_count, pending_clusters;
  int sent_items;
  int cycles;
  bit no_gaps;

  hit_coincidence_clusterer i_dut (.*);
  hcc_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("hit_coincidence_clusterer verification failed");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  initial begin
    int run;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      run = gap_len();
      if (run > 0) begin
        out_ready = 1'b0;
        repeat (run) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  task automatic send(input hcc_tb_pkg::kind_e k, input logic [31:0] sec, input int coarse,
                      input int fine, input logic [1:0] plane, input logic [15:0] chg);
    int g;
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    hit_second = sec;
    hit_coarse_ns = 30'(coarse);
    hit_fine_ns = 30'(fine);
    hit_plane = plane;
    hit_charge = chg;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic request();
    send(hcc_tb_pkg::KIND_CLUSTER, $urandom, int'($urandom_range(0, NS_MAX)),
         int'($urandom_range(0, NS_MAX)), 2'($urandom), 16'($urandom));
  endtask

  task automatic set_window(input logic [29:0] w);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_clusters != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = w;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic longint clamp_ns(input longint v);
    if (v < 0) return 0;
    if (v > NS_MAX) return NS_MAX;
    return v;
  endfunction

  task automatic random_event(input longint win);
    int n;
    logic [31:0] secs [2];
    longint base, cbase, span;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
    for (int s = 0; s < 2; s++)
      case ($urandom_range(0, 3))
        0: secs[s] = 32'd0;
        1: secs[s] = 32'hFFFF_FFFF;
        default: secs[s] = $urandom;
      endcase
    base = $urandom_range(0, NS_MAX);
    cbase = $urandom_range(0, NS_MAX);
    span = (win > 0) ? win * 2 : longint'(4);
    if (span > NS_MAX) span = NS_MAX;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(hcc_tb_pkg::KIND_LOAD, $urandom, int'($urandom_range(0, NS_MAX)),
             int'($urandom_range(0, NS_MAX)), 2'($urandom), 16'($urandom));
      else
        send(hcc_tb_pkg::KIND_LOAD, secs[1'($urandom_range(0, 1))],
             int'(clamp_ns(cbase + longint'($urandom_range(0, 2000)) - 1000)),
             int'(clamp_ns(base + longint'($urandom_range(0, 32'(span))) - span / 2)),
             2'($urandom), 16'($urandom));
      if ($urandom_range(0, 6) == 0) request();
    end
    repeat (n + $urandom_range(0, 1)) request();
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [29:0] windows [5];
    int budget;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = hcc_tb_pkg::KIND_LOAD;
    hit_second = '0;
    hit_coarse_ns = '0;
    hit_fine_ns = '0;
    hit_plane = '0;
    hit_charge = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    sent_items = 0;
    no_gaps = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store request, then loads interleaved with requests
    request();
    set_window(30'd100);
    send(hcc_tb_pkg::KIND_LOAD, 32'd0, 0, 500, 2'd0, 16'd0);
    send(hcc_tb_pkg::KIND_LOAD, 32'd0, NS_MAX, 599, 2'd1, 16'hFFFF);
    send(hcc_tb_pkg::KIND_LOAD, 32'd0, 10, 600, 2'd2, 16'h0001);
    send(hcc_tb_pkg::KIND_LOAD, 32'd0, 20, 401, 2'd3, 16'h8000);
    send(hcc_tb_pkg::KIND_LOAD, 32'hFFFF_FFFF, NS_MAX, NS_MAX, 2'd3, 16'hFFFF);
    request();
    send(hcc_tb_pkg::KIND_LOAD, 32'hFFFF_FFFF, 0, 0, 2'd2, 16'h1234);
    send(hcc_tb_pkg::KIND_LOAD, 32'd0, 7, 550, 2'd1, 16'h00FF);
    repeat (5) request();

    // zero window: every cluster is just its seed
    set_window(30'd0);
    repeat (3) send(hcc_tb_pkg::KIND_LOAD, 32'd5, 1000, 1000, 2'd1, 16'd77);
    repeat (4) request();

    // widest window and a store overrun
    set_window(30'd1000000000);
    for (int i = 0; i < hcc_pkg::MAX_HITS_DEF + 2; i++)
      send(hcc_tb_pkg::KIND_LOAD, 32'hFFFF_FFFF, (i % 2) ? NS_MAX : 0,
           (i % 2) ? NS_MAX : 0, 2'(i), 16'hFFFF);
    repeat (2) request();

    windows = '{30'd1, 30'($urandom_range(2, 5000)), 30'd100, 30'd1000000000,
                30'($urandom_range(0, 1000000000))};
    for (int p = 0; p < 5; p++) begin
      set_window(windows[p]);
      budget = sent_items + ITEM_TARGET / 5;
      while (sent_items < budget) random_event(longint'(windows[p]));
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_clusters != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (fail_count == 0) begin
      $display("hit_coincidence_clusterer verification clean");
    end else begin
      $display("hit_coincidence_clusterer verification failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/hcc_pkg.sv
rtl/hcc_div.sv
rtl/hcc_store.sv
rtl/hit_coincidence_clusterer.sv
bench/hcc_tb_pkg.sv
bench/hcc_checker.sv
bench/tb_hit_coincidence_clusterer.sv
